>>> design/gwmm_pkg.sv
// gwmm_pkg: types, constants and state codes of the window min/max filter.
// No dependencies; used by every module of the block.
package gwmm_pkg;

    localparam int unsigned IMAGE_WIDTH  = 512;
    localparam int unsigned IMAGE_HEIGHT = 512;
    localparam int unsigned MAX_WINDOW   = 15;

    localparam logic [7:0] PIX_MAX = 8'd255;
    localparam logic [7:0] PIX_MIN = 8'd0;

    localparam logic [3:0] WINDOW_RESET = 4'd3;

    localparam int unsigned ADDR_W = 3;
    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic REG_OPERATION   = 1'b1;

    typedef struct packed {
        logic [7:0] pixel_in;
        logic       padding;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_last;
    } t_pix_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RD,
        S_ACC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic init;
        logic acc;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic emit_due;
        logic last;
    } t_status;

endpackage

>>> design/grayscale_window_min_max_filter.sv
// Channel  | valid        | stall        | payload
// input    | i_in_valid   | o_in_stall   | i_in_data  (t_pix_in)
// output   | o_out_valid  | i_out_stall  | o_out_data (t_pix_out)
// config   | APB write: psel & penable & pwrite, reg i at 4*i
// One item at a time: an item with no result goes back to idle, a windowed
// result reads w*w taps (w = effective window side), a border result one tap;
// each tap is a line store read then an accumulate; output stall holds the result.
// Synchronous active-low reset; the line store is not cleared.
// Depends on gwmm_pkg, gwmm_ctrl, gwmm_dpath.
module grayscale_window_min_max_filter #(
    parameter int unsigned ImageWidth  = gwmm_pkg::IMAGE_WIDTH,
    parameter int unsigned ImageHeight = gwmm_pkg::IMAGE_HEIGHT,
    parameter int unsigned MaxWindow   = gwmm_pkg::MAX_WINDOW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  gwmm_pkg::t_pix_in             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output gwmm_pkg::t_pix_out            o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gwmm_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [3:0]        r_window_size;
    logic              r_operation;
    gwmm_pkg::t_cmd    cmd;
    gwmm_pkg::t_status status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= gwmm_pkg::WINDOW_RESET;
            r_operation   <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                gwmm_pkg::REG_WINDOW_SIZE: r_window_size <= pwdata[3:0];
                gwmm_pkg::REG_OPERATION:   r_operation   <= pwdata[0];
                default:                   r_operation   <= r_operation;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            gwmm_pkg::REG_WINDOW_SIZE: prdata = {28'd0, r_window_size};
            gwmm_pkg::REG_OPERATION:   prdata = {31'd0, r_operation};
            default:                   prdata = '0;
        endcase
    end

    gwmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    gwmm_dpath #(
        .ImageWidth  (ImageWidth),
        .ImageHeight (ImageHeight),
        .MaxWindow   (MaxWindow)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_in_data     (i_in_data),
        .i_window_size (r_window_size),
        .i_operation   (r_operation),
        .o_out_data    (o_out_data)
    );

endmodule

>>> design/gwmm_dpath.sv
// gwmm_dpath: line store memory, frame counters, window address walk, min/max accumulator.
// Depends on gwmm_pkg.
module gwmm_dpath #(
    parameter int unsigned ImageWidth  = gwmm_pkg::IMAGE_WIDTH,
    parameter int unsigned ImageHeight = gwmm_pkg::IMAGE_HEIGHT,
    parameter int unsigned MaxWindow   = gwmm_pkg::MAX_WINDOW
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gwmm_pkg::t_cmd     i_cmd,
    output gwmm_pkg::t_status  o_status,
    input  gwmm_pkg::t_pix_in  i_in_data,
    input  logic [3:0]         i_window_size,
    input  logic               i_operation,
    output gwmm_pkg::t_pix_out o_out_data
);

    localparam int unsigned Depth  = (MaxWindow - 1) * ImageWidth + MaxWindow;
    localparam int unsigned Frame  = ImageWidth * ImageHeight;
    localparam int unsigned AW     = $clog2(Depth);
    localparam int unsigned RW     = $clog2(Frame + 1);
    localparam int unsigned CW     = $clog2(Frame + Depth + 1);
    localparam int unsigned XW     = $clog2(ImageWidth);
    localparam int unsigned YW     = $clog2(ImageHeight);
    localparam int unsigned SW     = $clog2(ImageWidth + 1);

    logic [7:0] mem [Depth];

    logic [AW-1:0] r_wptr, r_optr, r_raddr;
    logic [RW-1:0] r_recv, r_ocnt;
    logic [XW-1:0] r_ocol;
    logic [YW-1:0] r_orow;
    logic [3:0]    r_h;
    logic [CW-1:0] r_delay;
    logic [4:0]    r_dx, r_dy;
    logic          r_border, r_op;
    logic [7:0]    r_best, r_rdata;

    logic [4:0]    w_eff;
    logic [3:0]    h_eff;
    logic [4:0]    span;
    logic          border;
    logic [CW-1:0] start_sum;
    logic [AW-1:0] start_addr;
    logic [AW:0]   step_sum;
    logic [AW:0]   step_inc;
    logic [7:0]    best_next;
    logic          is_last_out;

    function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] a);
        logic [AW:0] s;
        s = {1'b0, a} + (AW+1)'(1);
        if (s >= (AW+1)'(Depth)) begin
            s = '0;
        end
        return s[AW-1:0];
    endfunction

    always_comb begin
        if (i_window_size == 4'd0) begin
            w_eff = 5'd1;
        end else if ({1'b0, i_window_size} > 5'(MaxWindow)) begin
            w_eff = 5'(MaxWindow);
        end else begin
            w_eff = {1'b0, i_window_size};
        end
        if (!w_eff[0]) begin
            w_eff = w_eff - 5'd1;
        end
        h_eff = w_eff[4:1];
    end

    always_ff @(posedge i_clk) begin
        r_h     <= h_eff;
        r_delay <= CW'(h_eff) * CW'(ImageWidth) + CW'(h_eff);
    end

    assign span = {r_h, 1'b0};

    assign border = (XW+1)'(r_ocol) < (XW+1)'(r_h)
                 || (SW+1)'(r_ocol) + (SW+1)'(r_h) >= (SW+1)'(ImageWidth)
                 || (YW+1)'(r_orow) < (YW+1)'(r_h)
                 || (YW+2)'(r_orow) + (YW+2)'(r_h) >= (YW+2)'(ImageHeight);

    always_comb begin
        if (CW'(r_optr) >= r_delay) begin
            start_sum = CW'(r_optr) - r_delay;
        end else begin
            start_sum = CW'(r_optr) + CW'(Depth) - r_delay;
        end
        start_addr = start_sum[AW-1:0];
    end

    always_comb begin
        if (r_dx == span) begin
            step_inc = (AW+1)'(ImageWidth) - (AW+1)'(span);
        end else begin
            step_inc = (AW+1)'(1);
        end
        step_sum = {1'b0, r_raddr} + step_inc;
        if (step_sum >= (AW+1)'(Depth)) begin
            step_sum = step_sum - (AW+1)'(Depth);
        end
    end

    always_comb begin
        if (r_border) begin
            best_next = r_rdata;
        end else if (r_op) begin
            best_next = (r_rdata > r_best) ? r_rdata : r_best;
        end else begin
            best_next = (r_rdata < r_best) ? r_rdata : r_best;
        end
    end

    assign is_last_out = r_ocnt == RW'(Frame - 1);

    assign o_status.emit_due = (r_recv == RW'(Frame))
                            || (CW'(r_recv) > CW'(r_ocnt) + r_delay);
    assign o_status.last = r_border || (r_dx == span && r_dy == span);

    assign o_out_data.pixel_out  = r_best;
    assign o_out_data.frame_last = is_last_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !i_in_data.padding && r_recv != RW'(Frame)) begin
            mem[r_wptr] <= i_in_data.pixel_in;
        end
        r_rdata <= mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_recv <= '0;
            r_optr <= '0;
            r_ocnt <= '0;
            r_ocol <= '0;
            r_orow <= '0;
        end else if (i_cmd.accept) begin
            if (!i_in_data.padding && r_recv != RW'(Frame)) begin
                r_wptr <= inc_wrap(r_wptr);
                r_recv <= r_recv + RW'(1);
            end
        end else if (i_cmd.emit) begin
            if (is_last_out) begin
                r_wptr <= '0;
                r_recv <= '0;
                r_optr <= '0;
                r_ocnt <= '0;
                r_ocol <= '0;
                r_orow <= '0;
            end else begin
                r_optr <= inc_wrap(r_optr);
                r_ocnt <= r_ocnt + RW'(1);
                if (r_ocol == XW'(ImageWidth - 1)) begin
                    r_ocol <= '0;
                    r_orow <= r_orow + YW'(1);
                end else begin
                    r_ocol <= r_ocol + XW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_border <= border;
            r_op     <= i_operation;
            r_raddr  <= border ? r_optr : start_addr;
            r_dx     <= '0;
            r_dy     <= '0;
            r_best   <= i_operation ? gwmm_pkg::PIX_MIN : gwmm_pkg::PIX_MAX;
        end else begin
            if (i_cmd.acc) begin
                r_best <= best_next;
            end
            if (i_cmd.step) begin
                r_raddr <= step_sum[AW-1:0];
                if (r_dx == span) begin
                    r_dx <= '0;
                    r_dy <= r_dy + 5'd1;
                end else begin
                    r_dx <= r_dx + 5'd1;
                end
            end
        end
    end

endmodule

>>> design/gwmm_ctrl.sv
// gwmm_ctrl: sequencer for accept, window scan and result handoff.
// Depends on gwmm_pkg.
module gwmm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  gwmm_pkg::t_status i_status,
    output gwmm_pkg::t_cmd    o_cmd
);

    gwmm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gwmm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gwmm_pkg::S_IDLE:  if (i_in_valid) n_state = gwmm_pkg::S_CHECK;
            gwmm_pkg::S_CHECK: n_state = i_status.emit_due ? gwmm_pkg::S_RD : gwmm_pkg::S_IDLE;
            gwmm_pkg::S_RD:    n_state = gwmm_pkg::S_ACC;
            gwmm_pkg::S_ACC:   n_state = i_status.last ? gwmm_pkg::S_OUT : gwmm_pkg::S_RD;
            gwmm_pkg::S_OUT:   if (!i_out_stall) n_state = gwmm_pkg::S_IDLE;
            default:           n_state = gwmm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            gwmm_pkg::S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            gwmm_pkg::S_CHECK: o_cmd.init = i_status.emit_due;
            gwmm_pkg::S_RD:    o_cmd = '0;
            gwmm_pkg::S_ACC: begin
                o_cmd.acc  = 1'b1;
                o_cmd.step = !i_status.last;
            end
            gwmm_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                o_cmd.emit  = !i_out_stall;
            end
            default: o_cmd = '0;
        endcase
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.accept, o_cmd.init, o_cmd.acc, o_cmd.emit}))
        else $error("more than one datapath command");
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == gwmm_pkg::S_CHECK)
        else $error("accept not followed by check");
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == gwmm_pkg::S_IDLE && !o_out_valid))
        else $error("result not retired after handoff");

endmodule
